// File: src/cia_pkg.sv
// ----------------------------------------------------------------------------
// cia_pkg
// types, opcodes and constants shared by the checked integer alu
// ----------------------------------------------------------------------------
package cia_pkg;

    localparam int unsigned DATA_W = 64;
    localparam int unsigned HALF_W = 32;

    typedef enum logic [2:0] {
        OP_ADD = 3'd0,
        OP_SUB = 3'd1,
        OP_MUL = 3'd2,
        OP_DIV = 3'd3,
        OP_REM = 3'd4,
        OP_MOD = 3'd5,
        OP_POW = 3'd6,
        OP_BAD = 3'd7
    } t_kind;

    typedef struct packed {
        logic [2:0]               kind;
        logic                     narrow_mode;
        logic signed [DATA_W-1:0] left_operand;
        logic signed [DATA_W-1:0] right_operand;
    } t_in_item;

    typedef struct packed {
        logic signed [DATA_W-1:0] result_value;
        logic                     range_error;
    } t_out_item;

    // request to and answer from the shared multiplier
    typedef struct packed {
        logic              start;
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] b;
    } t_mul_req;

    typedef struct packed {
        logic              done;
        logic              ovf;
        logic [DATA_W-1:0] prod;
    } t_mul_rsp;

    function automatic logic in_narrow(input logic [DATA_W-1:0] v);
        logic [DATA_W-1:0] s;
        s = v + 64'h0000_0000_8000_0000;
        return s[DATA_W-1:HALF_W] == '0;
    endfunction

endpackage

// File: src/cia_mul.sv
// ----------------------------------------------------------------------------
// cia_mul
// shift-add signed 64x64 multiplier with 64-bit overflow detect, 1 bit/cycle
// ----------------------------------------------------------------------------
module cia_mul
    import cia_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_mul_req i_req,
    output t_mul_rsp o_rsp
);

    logic              r_busy, n_busy;
    logic [6:0]        r_cnt, n_cnt;
    logic [DATA_W-1:0] r_x, n_x;     // multiplicand magnitude, shifted left
    logic [DATA_W-1:0] r_y, n_y;     // multiplier magnitude, shifted right
    logic [DATA_W:0]   r_acc, n_acc; // 65 bits, top bit sticky overflow
    logic              r_xhi, n_xhi; // a set bit has left r_x
    logic              r_neg, n_neg;
    logic              r_done, n_done;

    logic [DATA_W-1:0] ma, mb, lo;
    logic [DATA_W:0]   sum;

    always_comb begin
        ma = i_req.a[DATA_W-1] ? (~i_req.a + 1'b1) : i_req.a;
        mb = i_req.b[DATA_W-1] ? (~i_req.b + 1'b1) : i_req.b;
        n_busy = r_busy;
        n_cnt  = r_cnt;
        n_x    = r_x;
        n_y    = r_y;
        n_acc  = r_acc;
        n_xhi  = r_xhi;
        n_neg  = r_neg;
        n_done = 1'b0;
        sum    = {1'b0, r_acc[DATA_W-1:0]} + {1'b0, r_x};
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_x    = ma;
            n_y    = mb;
            n_acc  = '0;
            n_xhi  = 1'b0;
            n_neg  = i_req.a[DATA_W-1] ^ i_req.b[DATA_W-1];
        end else if (r_busy) begin
            if (r_y[0]) begin
                n_acc = {r_acc[DATA_W] | sum[DATA_W] | r_xhi, sum[DATA_W-1:0]};
            end
            n_xhi = r_xhi | r_x[DATA_W-1];
            n_x   = r_x << 1;
            n_y   = r_y >> 1;
            n_cnt = r_cnt + 7'd1;
            if (r_cnt == 7'd63) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_x   <= n_x;
        r_y   <= n_y;
        r_acc <= n_acc;
        r_xhi <= n_xhi;
        r_neg <= n_neg;
    end

    always_comb begin
        lo = r_acc[DATA_W-1:0];
        o_rsp.done = r_done;
        o_rsp.prod = r_neg ? (~lo + 1'b1) : lo;
        if (r_acc[DATA_W])
            o_rsp.ovf = 1'b1;
        else if (r_neg)
            o_rsp.ovf = lo > 64'h8000_0000_0000_0000;
        else
            o_rsp.ovf = lo[DATA_W-1];
    end

endmodule

// File: src/checked_integer_alu.sv
// ----------------------------------------------------------------------------
// checked_integer_alu
// overflow-checked signed 64-bit alu: add, sub, mul, div, rem, mod, power
// ----------------------------------------------------------------------------
// power: one multiply per set exponent bit and per squaring (at most
// 63 and 62), each on the shared multiplier, and a pass through S_PWAIT after each squaring
// throughput: one item at a time, busy is high from accept until the strobe
// the receiver cannot stall; o_done pulses for one cycle with the result
// reset: synchronous active low, returns the sequencer to idle
module checked_integer_alu
    import cia_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    output logic      busy,
    input  t_in_item  i_item,
    output logic      o_done,
    output t_out_item o_item
);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_DISP = 6'b000010,
        S_DIV  = 6'b000100,
        S_MUL  = 6'b001000,
        S_PWAIT= 6'b010000,
        S_OUT  = 6'b100000
    } t_state;

    t_state r_state, n_state;

    logic [DATA_W-1:0] r_a, n_a;       // left operand / running base
    logic [DATA_W-1:0] r_b, n_b;       // right operand / exponent left
    logic [2:0]        r_kind, n_kind;
    logic              r_narrow, n_narrow;
    logic [DATA_W-1:0] r_res, n_res;
    logic              r_err, n_err;
    logic              r_pw_sq, n_pw_sq; // power: squaring done, base ready
    // restoring divider
    logic [DATA_W-1:0] r_q, n_q;
    logic [DATA_W-1:0] r_rm, n_rm;
    logic [DATA_W-1:0] r_d, n_d;
    logic [6:0]        r_cnt, n_cnt;
    logic              r_done, n_done;

    t_mul_req mul_req;
    t_mul_rsp mul_rsp;

    cia_mul u_mul (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (mul_req),
        .o_rsp  (mul_rsp)
    );

    logic [DATA_W-1:0] add_r, sub_r, ma, mb, q_s, m_s, m_f;
    logic [DATA_W:0]   trial;
    logic              a_n, b_n;
    logic [DATA_W-1:0] min_v;

    assign busy = (r_state != S_IDLE);

    always_comb begin
        min_v  = {1'b1, {(DATA_W-1){1'b0}}};
        a_n    = r_a[DATA_W-1];
        b_n    = r_b[DATA_W-1];
        add_r  = r_a + r_b;
        sub_r  = r_a - r_b;
        ma     = a_n ? (~r_a + 1'b1) : r_a;
        mb     = b_n ? (~r_b + 1'b1) : r_b;
        trial  = {r_rm, r_q[DATA_W-1]} - {1'b0, r_d};
        q_s    = (a_n ^ b_n) ? (~r_q + 1'b1) : r_q;
        m_s    = a_n ? (~r_rm + 1'b1) : r_rm;
        m_f    = m_s;
        if (r_kind == OP_MOD && m_s != '0 && (m_s[DATA_W-1] != b_n))
            m_f = m_s + r_b;

        n_state  = r_state;
        n_a      = r_a;
        n_b      = r_b;
        n_kind   = r_kind;
        n_narrow = r_narrow;
        n_res    = r_res;
        n_err    = r_err;
        n_pw_sq  = r_pw_sq;
        n_q      = r_q;
        n_rm     = r_rm;
        n_d      = r_d;
        n_cnt    = r_cnt;
        n_done   = 1'b0;
        mul_req  = '{start: 1'b0, a: r_res, b: r_a};

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_kind   = i_item.kind;
                    n_narrow = i_item.narrow_mode;
                    n_a      = i_item.left_operand;
                    n_b      = i_item.right_operand;
                    n_res    = '0;
                    n_err    = 1'b0;
                    n_state  = S_DISP;
                end
            end
            S_DISP: begin
                n_state = S_OUT;
                case (r_kind)
                    OP_ADD: begin
                        n_res = add_r;
                        n_err = (a_n == b_n) && (add_r[DATA_W-1] != a_n);
                    end
                    OP_SUB: begin
                        n_res = sub_r;
                        n_err = (a_n != b_n) && (sub_r[DATA_W-1] != a_n);
                    end
                    OP_MUL: begin
                        mul_req = '{start: 1'b1, a: r_a, b: r_b};
                        n_state = S_MUL;
                    end
                    OP_DIV, OP_REM, OP_MOD: begin
                        if (r_b == '0) begin
                            n_err = 1'b1;
                        end else if (r_a == min_v && r_b == '1) begin
                            n_err = (r_kind == OP_DIV);
                        end else begin
                            n_q     = ma;
                            n_d     = mb;
                            n_rm    = '0;
                            n_cnt   = '0;
                            n_state = S_DIV;
                        end
                    end
                    OP_POW: begin
                        if (b_n) begin
                            n_err = 1'b1;
                        end else begin
                            n_res   = {{(DATA_W-1){1'b0}}, 1'b1};
                            n_state = S_PWAIT;
                            n_pw_sq = 1'b1; // pretend a squaring just ended
                        end
                    end
                    default: n_err = 1'b1;
                endcase
            end
            S_DIV: begin
                n_cnt = r_cnt + 7'd1;
                if (!trial[DATA_W]) begin
                    n_rm = trial[DATA_W-1:0];
                    n_q  = {r_q[DATA_W-2:0], 1'b1};
                end else begin
                    n_rm = {r_rm[DATA_W-2:0], r_q[DATA_W-1]};
                    n_q  = {r_q[DATA_W-2:0], 1'b0};
                end
                if (r_cnt == 7'd64) begin
                    n_res   = (r_kind == OP_DIV) ? q_s : m_f;
                    n_state = S_OUT;
                    n_rm    = r_rm;
                    n_q     = r_q;
                end
            end
            S_MUL: begin
                if (mul_rsp.done) begin
                    n_res   = mul_rsp.prod;
                    n_err   = mul_rsp.ovf;
                    n_state = S_OUT;
                end
            end
            S_PWAIT: begin
                // step of square-and-multiply, one product in flight at a time
                if (r_pw_sq) begin
                    // base is ready; multiply into result if low exponent bit set
                    if (r_b == '0) begin
                        n_state = S_OUT;
                    end else if (r_b[0]) begin
                        mul_req = '{start: 1'b1, a: r_res, b: r_a};
                        n_pw_sq = 1'b0;
                        n_state = S_MUL;
                        n_kind  = OP_POW;
                    end else begin
                        n_b = r_b >> 1;
                        if ((r_b >> 1) != '0) begin
                            mul_req = '{start: 1'b1, a: r_a, b: r_a};
                            n_pw_sq = 1'b0;
                            n_state = S_MUL;
                        end else begin
                            n_state = S_OUT;
                        end
                    end
                end
            end
            S_OUT: begin
                n_done  = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase

        // power products return through the multiply state
        if (r_state == S_MUL && r_kind == OP_POW && mul_rsp.done) begin
            n_res   = r_res;
            n_err   = r_err;
            if (r_b[0] && !r_pw_sq && r_cnt == 7'd1) begin
                n_res = mul_rsp.prod;
            end
            if (mul_rsp.ovf || (r_narrow && !in_narrow(mul_rsp.prod))) begin
                n_err   = 1'b1;
                n_state = S_OUT;
            end else if (r_cnt == 7'd1) begin
                // result multiply done, now shift exponent and square
                n_b     = r_b >> 1;
                n_cnt   = '0;
                if ((r_b >> 1) != '0) begin
                    mul_req = '{start: 1'b1, a: r_a, b: r_a};
                    n_state = S_MUL;
                end else begin
                    n_state = S_OUT;
                end
            end else begin
                n_a     = mul_rsp.prod;
                n_pw_sq = 1'b1;
                n_state = S_PWAIT;
            end
        end
        // tag result multiplies in power so the return can be told apart
        if (r_state == S_PWAIT && r_pw_sq && r_b != '0 && r_b[0])
            n_cnt = 7'd1;
        if (r_state == S_PWAIT && r_pw_sq && r_b != '0 && !r_b[0])
            n_cnt = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
        r_a      <= n_a;
        r_b      <= n_b;
        r_kind   <= n_kind;
        r_narrow <= n_narrow;
        r_res    <= n_res;
        r_err    <= n_err;
        r_pw_sq  <= n_pw_sq;
        r_q      <= n_q;
        r_rm     <= n_rm;
        r_d      <= n_d;
        r_cnt    <= n_cnt;
    end

    // result register, final range check folded in
    logic              r_oerr;
    logic [DATA_W-1:0] r_oval;
    logic              fail;

    assign fail = r_err || (r_narrow && !in_narrow(r_res));

    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT) begin
            r_oerr <= fail;
            r_oval <= fail ? '0 : r_res;
        end
    end

    assign o_done              = r_done;
    assign o_item.result_value = r_oval;
    assign o_item.range_error  = r_oerr;

    // a result strobe is only raised for an item that was in flight
    a_no_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(busy)) else $error("strobe without item");
    // an error result always reads zero
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_item.range_error |-> o_item.result_value == '0)
        else $error("error result not zero");
    // busy falls in the cycle the strobe is raised
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy) else $error("busy after strobe");

endmodule

// File: bench/tb_checked_integer_alu.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_checked_integer_alu
// random and directed items through the checked alu, each result compared
// against an in-bench prediction of the overflow-checked arithmetic
// ----------------------------------------------------------------------------
module tb_checked_integer_alu;
    import cia_pkg::*;

    localparam logic [63:0] MIN64 = 64'h8000_0000_0000_0000;
    localparam logic [63:0] MAX64 = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] ALL1  = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] MIN32 = 64'hFFFF_FFFF_8000_0000;
    localparam logic [63:0] MAX32 = 64'h0000_0000_7FFF_FFFF;
    localparam int N_RANDOM = 450;

    logic      clk;
    logic      rst_n;
    logic      start;
    logic      busy;
    t_in_item  in_item;
    logic      done;
    t_out_item out_item;

    t_in_item  pending_items[$];
    t_out_item expected_results[$];
    int        fail_count;
    bit        stim_done;
    bit        drain_hold;   // sender waits until everything has come back
    int        gap_left;

    checked_integer_alu u_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .start   (start),
        .busy    (busy),
        .i_item  (in_item),
        .o_done  (done),
        .o_item  (out_item)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------------

    function automatic bit fits_mode(input logic [63:0] v, input bit narrow);
        logic [63:0] s;
        s = v + 64'h8000_0000;
        return !narrow || (s[63:32] == 32'd0);
    endfunction

    // signed multiply via 128-bit magnitudes; returns 1 on 64-bit overflow
    function automatic bit mul_ovf(input logic [63:0] a, input logic [63:0] b,
                                   output logic [63:0] prod);
        logic          neg;
        logic [63:0]   ma;
        logic [63:0]   mb;
        logic [127:0]  full;
        neg  = a[63] ^ b[63];
        ma   = a[63] ? -a : a;
        mb   = b[63] ? -b : b;
        full = {64'd0, ma} * {64'd0, mb};
        prod = neg ? -full[63:0] : full[63:0];
        if (full[127:64] != 0) return 1'b1;
        return neg ? (full[63:0] > MIN64) : (full[63:0] >= MIN64);
    endfunction

    function automatic t_out_item checked_result(input t_in_item it);
        t_out_item   res;
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] r;
        logic [63:0] ma;
        logic [63:0] mb;
        logic [63:0] q;
        bit          err;
        bit          nm;
        a   = it.left_operand;
        b   = it.right_operand;
        nm  = it.narrow_mode;
        r   = '0;
        err = 1'b0;
        case (t_kind'(it.kind))
            OP_ADD: begin
                r   = a + b;
                err = (a[63] == b[63]) && (r[63] != a[63]);
            end
            OP_SUB: begin
                r   = a - b;
                err = (a[63] != b[63]) && (r[63] != a[63]);
            end
            OP_MUL: err = mul_ovf(a, b, r);
            OP_DIV, OP_REM, OP_MOD: begin
                if (b == 0) begin
                    err = 1'b1;
                end else if (a == MIN64 && b == ALL1) begin
                    // minimum over minus one only overflows the quotient
                    err = (t_kind'(it.kind) == OP_DIV);
                end else begin
                    ma = a[63] ? -a : a;
                    mb = b[63] ? -b : b;
                    if (t_kind'(it.kind) == OP_DIV) begin
                        q = ma / mb;
                        r = (a[63] != b[63]) ? -q : q;
                    end else begin
                        q = ma % mb;
                        r = a[63] ? -q : q;
                        // mod takes the divisor's sign
                        if (t_kind'(it.kind) == OP_MOD && r != 0 && r[63] != b[63])
                            r = r + b;
                    end
                end
            end
            OP_POW: begin
                if (b[63]) begin
                    err = 1'b1;
                end else begin
                    r = 64'd1;
                    while (b != 0 && !err) begin
                        if (b[0]) begin
                            if (mul_ovf(r, a, r) || !fits_mode(r, nm)) err = 1'b1;
                        end
                        b = b >> 1;
                        if (b != 0 && !err) begin
                            if (mul_ovf(a, a, a) || !fits_mode(a, nm)) err = 1'b1;
                        end
                    end
                end
            end
            default: err = 1'b1;
        endcase
        if (err || !fits_mode(r, nm)) begin
            res.result_value = '0;
            res.range_error  = 1'b1;
        end else begin
            res.result_value = r;
            res.range_error  = 1'b0;
        end
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // operand biased towards extremes and values near the 32-bit limits
    function automatic logic [63:0] pick_operand();
        case ($urandom_range(0, 9))
            0: return MIN64 + 64'($urandom_range(0, 2));
            1: return MAX64 - 64'($urandom_range(0, 2));
            2: return MIN32 + 64'($urandom_range(0, 2)) - 64'd1;
            3: return MAX32 + 64'($urandom_range(0, 2)) - 64'd1;
            4, 5: return {{32{1'b0}}, $urandom()} - 64'h8000_0000;
            6: return 64'(signed'($urandom_range(0, 20)) - 10);
            default: return rand64();
        endcase
    endfunction

    task automatic queue_item(input t_kind k, input bit nm,
                              input logic [63:0] a, input logic [63:0] b);
        t_in_item it;
        it.kind          = k;
        it.narrow_mode   = nm;
        it.left_operand  = a;
        it.right_operand = b;
        pending_items.push_back(it);
    endtask

    initial begin
        t_in_item it;
        // directed: extremes, every opcode and the named corner cases
        queue_item(OP_ADD, 1'b0, MAX64, 64'd1);
        queue_item(OP_ADD, 1'b0, MIN64, ALL1);
        queue_item(OP_ADD, 1'b1, MAX32, 64'd0);
        queue_item(OP_ADD, 1'b1, MAX32, 64'd1);
        queue_item(OP_SUB, 1'b0, MIN64, 64'd1);
        queue_item(OP_SUB, 1'b1, MIN32, 64'd1);
        queue_item(OP_MUL, 1'b0, MIN64, ALL1);
        queue_item(OP_MUL, 1'b0, MIN64, 64'd1);
        queue_item(OP_MUL, 1'b1, 64'd65536, 64'd32768);
        queue_item(OP_DIV, 1'b0, 64'd7, 64'd0);
        queue_item(OP_REM, 1'b0, 64'd7, 64'd0);
        queue_item(OP_MOD, 1'b0, 64'd7, 64'd0);
        queue_item(OP_DIV, 1'b0, MIN64, ALL1);
        queue_item(OP_REM, 1'b0, MIN64, ALL1);
        queue_item(OP_MOD, 1'b0, MIN64, ALL1);
        queue_item(OP_DIV, 1'b0, -64'd7, 64'd2);
        queue_item(OP_REM, 1'b0, -64'd7, 64'd2);
        queue_item(OP_MOD, 1'b0, -64'd7, 64'd2);
        queue_item(OP_MOD, 1'b0, 64'd7, -64'd2);
        queue_item(OP_POW, 1'b0, MIN64, 64'd0);
        queue_item(OP_POW, 1'b0, 64'd3, ALL1);
        queue_item(OP_POW, 1'b0, 64'd2, 64'd62);
        queue_item(OP_POW, 1'b0, 64'd2, 64'd63);
        queue_item(OP_POW, 1'b1, -64'd2, 64'd31);
        queue_item(OP_BAD, 1'b1, MAX64, MIN64);
        // random: power mostly with small exponents so the run stays short
        for (int n = 0; n < N_RANDOM; n++) begin
            it.kind          = 3'($urandom_range(0, 7));
            it.narrow_mode   = 1'($urandom_range(0, 1));
            it.left_operand  = pick_operand();
            it.right_operand = pick_operand();
            if (t_kind'(it.kind) == OP_POW) begin
                if ($urandom_range(0, 9) < 7)
                    it.right_operand = 64'($urandom_range(0, 66));
                if ($urandom_range(0, 2) == 0)
                    it.left_operand = 64'(signed'($urandom_range(0, 8)) - 4);
            end
            pending_items.push_back(it);
        end
    end

    // ------------------------------------------------------------------------
    // driver: accepts at start && !busy, random gaps, one drain pause
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        if (!rst_n) begin
            start     <= 1'b0;
            in_item   <= '0;
            gap_left  <= 0;
            stim_done <= 1'b0;
            drain_hold <= 1'b0;
        end else begin
            // item accepted at this edge: predict it
            if (start && !busy) begin
                expected_results.push_back(checked_result(in_item));
            end
            if (start && busy) begin
                // held until the block takes it
            end else if (drain_hold && (expected_results.size() != 0 || start)) begin
                start <= 1'b0;
            end else if (gap_left > 0) begin
                start    <= 1'b0;
                gap_left <= gap_left - 1;
            end else if (pending_items.size() != 0) begin
                drain_hold <= 1'b0;
                in_item    <= pending_items.pop_front();
                start      <= 1'b1;
                // mostly short gaps, a few long, some none
                case ($urandom_range(0, 9))
                    0, 1, 2: gap_left <= 0;
                    9:       gap_left <= $urandom_range(20, 150);
                    default: gap_left <= $urandom_range(1, 4);
                endcase
                if (pending_items.size() == 200) drain_hold <= 1'b1;
            end else begin
                start     <= 1'b0;
                stim_done <= !start;
            end
        end
    end

    // ------------------------------------------------------------------------
    // monitor: each strobe is one result item, compared with the oldest
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        t_out_item want;
        if (rst_n && done) begin
            if (expected_results.size() == 0) begin
                $error("result with nothing expected: value %h error %b",
                       out_item.result_value, out_item.range_error);
                fail_count++;
            end else begin
                want = expected_results.pop_front();
                if (out_item.result_value !== want.result_value) begin
                    $error("result_value expected %h actual %h",
                           want.result_value, out_item.result_value);
                    fail_count++;
                end
                if (out_item.range_error !== want.range_error) begin
                    $error("range_error expected %b actual %b",
                           want.range_error, out_item.range_error);
                    fail_count++;
                end
            end
        end
    end

    // reset and end of run
    initial begin
        fail_count = 0;
        rst_n      = 1'b0;
        start      = 1'b0;
        in_item    = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        wait (stim_done && expected_results.size() == 0);
        repeat (100) @(posedge clk);
        if (fail_count == 0 && expected_results.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // watchdog: power can take 125 multiplies
    initial begin
        #200ms;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

// File: sim.f
src/cia_pkg.sv
src/cia_mul.sv
src/checked_integer_alu.sv
bench/tb_checked_integer_alu.sv
